/* rtl/ptd_pkg.sv */
// shared types and constants of the periodic task timer dispatcher
package ptd_pkg;

    localparam int SLOT_CAP = 4;
    localparam int CNT_W = 16;
    localparam int PADDR_W = 4;

    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_DISPATCH = 3'd1;
    localparam logic [2:0] KIND_ENABLE   = 3'd2;
    localparam logic [2:0] KIND_DISABLE  = 3'd3;
    localparam logic [2:0] KIND_REFRESH  = 3'd4;
    localparam logic [2:0] KIND_SET_TIME = 3'd5;
    localparam logic [2:0] KIND_QUERY    = 3'd6;

    localparam logic [1:0] STATUS_DISABLED = 2'd0;
    localparam logic [1:0] STATUS_ENABLED  = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

    typedef logic [SLOT_CAP-1:0][CNT_W-1:0] t_intervals;

    localparam t_intervals INTERVAL_RESET = '{16'd1000, 16'd20, 16'd20, 16'd50};

    typedef struct packed {
        logic [2:0]       kind;
        logic [2:0]       task_index;
        logic [CNT_W-1:0] time_value;
    } t_in_item;

    typedef struct packed {
        logic       granted;
        logic [2:0] granted_task;
        logic [1:0] enable_status;
    } t_out_item;

    typedef struct packed {
        logic     fire;
        t_in_item item;
    } t_slot_op;

endpackage

/* rtl/ptd_cfg_regs.sv */
// apb interval registers of the dispatcher
module ptd_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ptd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output ptd_pkg::t_intervals      o_interval
);
    import ptd_pkg::*;

    t_intervals r_interval;
    logic [1:0] w_reg_idx;
    logic       w_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (w_wr) begin
            r_interval[w_reg_idx] <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata     = {{(32-CNT_W){1'b0}}, r_interval[w_reg_idx]};
    assign o_interval = r_interval;

endmodule

/* rtl/ptd_slot_bank.sv */
// slot state: enable flags, countdowns, pending flags and their per-item update
module ptd_slot_bank #(
    parameter int NUM_TASKS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptd_pkg::t_slot_op   i_op,
    input  ptd_pkg::t_intervals i_interval,
    output ptd_pkg::t_out_item  o_result
);
    import ptd_pkg::*;

    localparam logic [3:0] NUM_SLOTS = 4'(NUM_TASKS);

    logic [NUM_TASKS-1:0]            r_en, n_en;
    logic [NUM_TASKS-1:0]            r_pend, n_pend;
    logic [NUM_TASKS-1:0][CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_TASKS-1:0]            w_sel;
    logic                            w_ok;
    logic                            w_found;
    t_out_item                       w_res;

    assign w_ok = ({1'b0, i_op.item.task_index} < NUM_SLOTS);

    always_comb begin
        for (int s = 0; s < NUM_TASKS; s++) begin
            w_sel[s] = w_ok && (i_op.item.task_index == 3'(s));
        end
    end

    always_comb begin
        n_en    = r_en;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        w_res   = '0;
        w_found = 1'b0;
        case (i_op.item.kind)
            KIND_TICK: begin
                for (int s = 0; s < NUM_TASKS; s++) begin
                    if (r_en[s] && (r_cnt[s] != '0)) begin
                        if (r_cnt[s] == CNT_W'(1)) begin
                            n_cnt[s]  = i_interval[s];
                            n_pend[s] = 1'b1;
                        end else begin
                            n_cnt[s] = r_cnt[s] - CNT_W'(1);
                        end
                    end
                end
            end
            KIND_DISPATCH: begin
                for (int s = 0; s < NUM_TASKS; s++) begin
                    if (!w_found && r_pend[s]) begin
                        w_found            = 1'b1;
                        n_pend[s]          = 1'b0;
                        w_res.granted      = 1'b1;
                        w_res.granted_task = 3'(s);
                    end
                end
            end
            KIND_ENABLE: begin
                for (int s = 0; s < NUM_TASKS; s++) begin
                    if (w_sel[s]) n_en[s] = 1'b1;
                end
            end
            KIND_DISABLE: begin
                for (int s = 0; s < NUM_TASKS; s++) begin
                    if (w_sel[s]) begin
                        n_en[s]  = 1'b0;
                        n_cnt[s] = i_interval[s];
                    end
                end
            end
            KIND_REFRESH: begin
                for (int s = 0; s < NUM_TASKS; s++) begin
                    if (w_sel[s]) n_cnt[s] = i_interval[s];
                end
            end
            KIND_SET_TIME: begin
                for (int s = 0; s < NUM_TASKS; s++) begin
                    if (w_sel[s]) begin
                        n_en[s]  = 1'b1;
                        n_cnt[s] = i_op.item.time_value;
                    end
                end
            end
            KIND_QUERY: begin
                if (!w_ok) begin
                    w_res.enable_status = STATUS_UNKNOWN;
                end else if (|(w_sel & r_en)) begin
                    w_res.enable_status = STATUS_ENABLED;
                end else begin
                    w_res.enable_status = STATUS_DISABLED;
                end
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= '1;
            r_pend <= '0;
            for (int s = 0; s < NUM_TASKS; s++) begin
                r_cnt[s] <= INTERVAL_RESET[s];
            end
        end else if (i_op.fire) begin
            r_en   <= n_en;
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

    assign o_result = w_res;

endmodule

/* rtl/periodic_task_timer_dispatcher_unit.sv */
// Periodic task timer dispatcher: up to NUM_TASKS slots, each with an enable
// flag, a 16-bit countdown reloaded from its interval register, and a pending
// flag. Ticks, dispatches and per-slot commands arrive as input items; every
// item yields exactly one result item. An accepted item is held in an input
// register and processed once the output register is free or being taken:
// then the slot state is updated and the result is captured in the output
// register. The block takes one item per cycle as long as results are taken.
// The interval registers sit on an APB-style port (byte address 4*slot,
// pready always high).
module periodic_task_timer_dispatcher_unit #(
    parameter int NUM_TASKS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ptd_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ptd_pkg::t_out_item          o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ptd_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       w_fire;
    t_slot_op   w_op;
    t_intervals w_interval;
    t_out_item  w_result;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    assign w_op.fire = w_fire;
    assign w_op.item = r_in_item;

    ptd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_interval (w_interval)
    );

    ptd_slot_bank #(
        .NUM_TASKS (NUM_TASKS)
    ) u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_interval (w_interval),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* bench/tb.sv */
// testbench for the periodic task timer dispatcher: random items checked against a slot predictor
module tb;
    import ptd_pkg::*;

    localparam int NUM_TASKS = 4;
    localparam int LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int NUM_PHASES = 5;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    t_in_item pending_items[$];
    t_out_item expected_results[$];
    int items_queued = 0;
    int items_taken = 0;
    bit failed = 1'b0;

    logic [CNT_W-1:0] slot_interval[SLOT_CAP];
    logic slot_on[SLOT_CAP];
    logic [CNT_W-1:0] slot_count[SLOT_CAP];
    logic slot_pend[SLOT_CAP];

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int send_gap = 0;
    bit send_burst = 1'b0;
    int recv_stall = 0;
    bit recv_burst = 1'b0;

    periodic_task_timer_dispatcher_unit #(.NUM_TASKS(NUM_TASKS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out_item advance_slots(t_in_item it);
        t_out_item r;
        int ix;
        bit ok;
        r = '0;
        ix = it.task_index;
        ok = ix < NUM_TASKS;
        case (it.kind)
            KIND_TICK: begin
                for (int s = 0; s < NUM_TASKS; s++) begin
                    if (slot_on[s] && slot_count[s] != 0) begin
                        slot_count[s] = slot_count[s] - 1'b1;
                        if (slot_count[s] == 0) begin
                            slot_count[s] = slot_interval[s];
                            slot_pend[s] = 1'b1;
                        end
                    end
                end
            end
            KIND_DISPATCH: begin
                for (int s = 0; s < NUM_TASKS; s++) begin
                    if (slot_pend[s] && !r.granted) begin
                        slot_pend[s] = 1'b0;
                        r.granted = 1'b1;
                        r.granted_task = 3'(s);
                    end
                end
            end
            KIND_ENABLE: begin
                if (ok) slot_on[ix] = 1'b1;
            end
            KIND_DISABLE: begin
                if (ok) begin
                    slot_count[ix] = slot_interval[ix];
                    slot_on[ix] = 1'b0;
                end
            end
            KIND_REFRESH: begin
                if (ok) slot_count[ix] = slot_interval[ix];
            end
            KIND_SET_TIME: begin
                if (ok) begin
                    slot_count[ix] = it.time_value;
                    slot_on[ix] = 1'b1;
                end
            end
            KIND_QUERY: begin
                if (!ok) r.enable_status = STATUS_UNKNOWN;
                else r.enable_status = slot_on[ix] ? STATUS_ENABLED : STATUS_DISABLED;
            end
            default: ;
        endcase
        return r;
    endfunction

    // monitor: bus writes, result checks, prediction of accepted items
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        out_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                slot_interval[paddr[3:2]] = pwdata[CNT_W-1:0];
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    failed = 1'b1;
                end else begin
                    t_out_item e;
                    e = expected_results.pop_front();
                    if (o_out_item.granted !== e.granted) begin
                        $error("granted: expected %0d, actual %0d", e.granted,
                               o_out_item.granted);
                        failed = 1'b1;
                    end
                    if (o_out_item.granted_task !== e.granted_task) begin
                        $error("granted_task: expected %0d, actual %0d", e.granted_task,
                               o_out_item.granted_task);
                        failed = 1'b1;
                    end
                    if (o_out_item.enable_status !== e.enable_status) begin
                        $error("enable_status: expected %0d, actual %0d", e.enable_status,
                               o_out_item.enable_status);
                        failed = 1'b1;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(advance_slots(i_in_item));
                items_taken++;
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
                i_in_item <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                send_gap <= send_burst ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 15) == 0) send_burst <= !send_burst;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin : recv_ctl
        int stall;
        if (i_rst_n) begin
            stall = recv_stall;
            if (out_taken) begin
                stall = recv_burst ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                recv_stall <= stall - 1;
            end else begin
                i_out_ready <= 1'b1;
                recv_stall <= 0;
            end
        end
    end

    task automatic push_item(logic [2:0] kind, logic [2:0] idx, logic [CNT_W-1:0] tval);
        t_in_item it;
        it.kind = kind;
        it.task_index = idx;
        it.time_value = tval;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_interval(int slot, logic [CNT_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * slot);
        pwdata <= {16'h0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure_phase(int phase);
        logic [CNT_W-1:0] v;
        for (int s = 0; s < SLOT_CAP; s++) begin
            case (phase)
                0: v = CNT_W'(s + 1);
                1: v = (s % 2 == 0) ? 16'hFFFF : CNT_W'(s);
                2: v = CNT_W'($urandom_range(1, 8));
                3: v = (s == 0) ? CNT_W'($urandom_range(1, 65535)) : CNT_W'($urandom_range(1, 5));
                default: v = (s == 3) ? 16'h0 : CNT_W'($urandom_range(2, 6));
            endcase
            write_interval(s, v);
        end
    endtask

    task automatic push_random_item();
        int sel;
        logic [2:0] kind;
        logic [2:0] idx;
        logic [CNT_W-1:0] tval;
        sel = $urandom_range(0, 99);
        if (sel < 35) kind = KIND_TICK;
        else if (sel < 55) kind = KIND_DISPATCH;
        else if (sel < 63) kind = KIND_ENABLE;
        else if (sel < 69) kind = KIND_DISABLE;
        else if (sel < 75) kind = KIND_REFRESH;
        else if (sel < 86) kind = KIND_SET_TIME;
        else if (sel < 97) kind = KIND_QUERY;
        else kind = KIND_UNUSED;
        idx = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel < 7) tval = CNT_W'($urandom_range(0, 12));
        else if (sel < 9) tval = CNT_W'($urandom);
        else tval = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0;
        push_item(kind, idx, tval);
    endtask

    initial begin
        for (int s = 0; s < SLOT_CAP; s++) begin
            slot_interval[s] = INTERVAL_RESET[s];
            slot_on[s] = 1'b1;
            slot_count[s] = INTERVAL_RESET[s];
            slot_pend[s] = 1'b0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset intervals: queries, empty dispatch, disabled pending slot, out of range slots
        push_item(KIND_QUERY, 3'd0, 16'h0);
        push_item(KIND_QUERY, 3'd4, 16'h0);
        push_item(KIND_QUERY, 3'd7, 16'hFFFF);
        push_item(KIND_DISPATCH, 3'd0, 16'h0);
        push_item(KIND_SET_TIME, 3'd0, 16'd1);
        push_item(KIND_SET_TIME, 3'd1, 16'd0);
        push_item(KIND_TICK, 3'd0, 16'h0);
        push_item(KIND_DISABLE, 3'd0, 16'h0);
        push_item(KIND_TICK, 3'd0, 16'h0);
        push_item(KIND_DISPATCH, 3'd0, 16'h0);
        push_item(KIND_DISPATCH, 3'd0, 16'h0);
        push_item(KIND_QUERY, 3'd0, 16'h0);
        push_item(KIND_ENABLE, 3'd0, 16'h0);
        push_item(KIND_SET_TIME, 3'd3, 16'hFFFF);
        push_item(KIND_REFRESH, 3'd5, 16'h0);
        push_item(KIND_DISABLE, 3'd6, 16'h0);
        push_item(KIND_ENABLE, 3'd4, 16'h0);
        push_item(KIND_SET_TIME, 3'd7, 16'hAAAA);
        push_item(KIND_UNUSED, 3'd7, 16'hFFFF);
        wait_drained();

        // zero interval fires once then idles, interval one fires every tick
        write_interval(0, 16'h0);
        write_interval(1, 16'h1);
        write_interval(2, 16'hFFFF);
        write_interval(3, 16'h3);
        push_item(KIND_SET_TIME, 3'd0, 16'd1);
        push_item(KIND_REFRESH, 3'd2, 16'h0);
        push_item(KIND_TICK, 3'd0, 16'h0);
        push_item(KIND_TICK, 3'd0, 16'h0);
        push_item(KIND_DISPATCH, 3'd0, 16'h0);
        push_item(KIND_DISPATCH, 3'd0, 16'h0);
        push_item(KIND_SET_TIME, 3'd1, 16'd1);
        push_item(KIND_TICK, 3'd0, 16'h0);
        push_item(KIND_DISPATCH, 3'd0, 16'h0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            configure_phase(p);
            repeat (RANDOM_PER_PHASE) push_random_item();
            wait_drained();
        end

        repeat (6) @(negedge i_clk);
        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

endmodule
